// ===== hdl/mrpt_pkg.sv =====
// mrpt_pkg: shared types, constants and functions for the 64-bit primality tester
// depends on nothing
package mrpt_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned NumBases = 7;
    localparam int unsigned QueueDepth = 2;

    typedef logic [WordWidth-1:0] word_t;

    // front classification passed to the back end
    typedef enum logic [1:0] {
        CLS_COMPOSITE = 2'd0,
        CLS_PRIME     = 2'd1,
        CLS_TEST      = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t  cls;
        word_t n;
        word_t d;
        logic [5:0] s;
    } job_t;

    function automatic word_t base_of(input logic [2:0] k);
        word_t b;
        b = '0;
        case (k)
            3'd0: b = word_t'(64'd2);
            3'd1: b = word_t'(64'd325);
            3'd2: b = word_t'(64'd9375);
            3'd3: b = word_t'(64'd28178);
            3'd4: b = word_t'(64'd450775);
            3'd5: b = word_t'(64'd9780504);
            3'd6: b = word_t'(64'd1795265022);
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/mrpt_front.sv =====
// mrpt_front: takes candidates, sorts out trivial cases, splits n-1 into d * 2^s
// depends on mrpt_pkg
module mrpt_front
    import mrpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  word_t candidate,
    output logic  job_valid,
    input  logic  job_stall,
    output job_t  job
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_SHIFT = 3'b010,
        F_OUT   = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;
    job_t    job_reg, job_next;

    assign in_stall  = (state_reg != F_IDLE);
    assign job_valid = (state_reg == F_OUT);
    assign job       = job_reg;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    job_next.n = candidate;
                    job_next.d = candidate - word_t'(1);
                    job_next.s = '0;
                    if (candidate < word_t'(2))
                    begin
                        job_next.cls = CLS_COMPOSITE;
                        state_next = F_OUT;
                    end
                    else if (!candidate[0])
                    begin
                        job_next.cls = (candidate == word_t'(2)) ? CLS_PRIME : CLS_COMPOSITE;
                        state_next = F_OUT;
                    end
                    else
                    begin
                        job_next.cls = CLS_TEST;
                        state_next = F_SHIFT;
                    end
                end
            end
            F_SHIFT:
            begin
                // one bit of the 2^s factor per cycle
                if (job_reg.d[0])
                    state_next = F_OUT;
                else
                begin
                    job_next.d = job_reg.d >> 1;
                    job_next.s = job_reg.s + 6'd1;
                end
            end
            F_OUT:
            begin
                if (!job_stall)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// ===== hdl/mrpt_queue.sv =====
// mrpt_queue: small register fifo between front and back end
// depends on mrpt_pkg
module mrpt_queue
    import mrpt_pkg::*;
#(
    parameter int unsigned Depth = QueueDepth
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_stall,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_stall,
    output job_t rd_data
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

    job_t              mem_reg [Depth];
    logic [PtrW-1:0]   wp_reg, rp_reg;
    logic [PtrW:0]     cnt_reg;
    logic              wr_go, rd_go;

    assign wr_stall = (cnt_reg == (PtrW+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_go    = wr_valid && !wr_stall;
    assign rd_go    = rd_valid && !rd_stall;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_go)
                wp_reg <= bump(wp_reg);
            if (rd_go)
                rp_reg <= bump(rp_reg);
            if (wr_go && !rd_go)
                cnt_reg <= cnt_reg + (PtrW+1)'(1);
            else if (!wr_go && rd_go)
                cnt_reg <= cnt_reg - (PtrW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== hdl/mrpt_mulmod.sv =====
// mrpt_mulmod: bit-serial (a * b) mod m, one double-and-add step per cycle
// depends on mrpt_pkg
module mrpt_mulmod
    import mrpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    input  word_t m,
    output logic  done,
    output word_t product
);

    logic       busy_reg;
    logic [5:0] bit_reg;
    word_t      acc_reg, a_reg, b_reg;
    word_t      dbl, sum, gap;

    always_comb
    begin
        // acc + acc mod m
        gap = m - acc_reg;
        dbl = (acc_reg >= gap) ? acc_reg - gap : acc_reg + acc_reg;
        gap = m - a_reg;
        sum = (dbl >= gap) ? dbl - gap : dbl + a_reg;
        if (!b_reg[bit_reg])
            sum = dbl;
    end

    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= 6'd63;
            end
            else if (busy_reg)
            begin
                bit_reg <= bit_reg - 6'd1;
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
            acc_reg <= sum;
    end

endmodule

// ===== hdl/mrpt_back.sv =====
// mrpt_back: runs the witness loop over the seven bases with one shared mulmod unit
// depends on mrpt_pkg, mrpt_mulmod
module mrpt_back
    import mrpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_stall,
    input  job_t job,
    output logic out_valid,
    input  logic out_stall,
    output logic flag
);

    typedef enum logic [9:0] {
        B_IDLE   = 10'b0000000001,
        B_BASE   = 10'b0000000010,
        B_RED    = 10'b0000000100,
        B_POW    = 10'b0000001000,
        B_PMUL   = 10'b0000010000,
        B_PSQ    = 10'b0000100000,
        B_CHECK  = 10'b0001000000,
        B_SQR    = 10'b0010000000,
        B_SQRW   = 10'b0100000000,
        B_OUT    = 10'b1000000000
    } bstate_t;

    bstate_t    state_reg;
    word_t      n_reg, d_reg, e_reg, x_reg, sq_reg;
    logic [5:0] s_reg, r_reg;
    logic [2:0] k_reg;
    logic       flag_reg;
    logic       mm_start;
    word_t      mm_a, mm_b, mm_p;
    logic       mm_done;
    word_t      nm1;
    logic       out_load;

    assign nm1       = n_reg - word_t'(1);
    assign job_stall = (state_reg != B_IDLE) || (out_valid && out_stall);
    assign flag      = flag_reg;
    assign out_load  = ((state_reg == B_IDLE) && job_valid && !job_stall
                        && (job.cls != CLS_TEST))
                    || ((state_reg == B_OUT) && (!out_valid || !out_stall));

    mrpt_mulmod u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .a       (mm_a),
        .b       (mm_b),
        .m       (n_reg),
        .done    (mm_done),
        .product (mm_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            mm_start  <= 1'b0;
        end
        else
        begin
            mm_start <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (job_valid && !job_stall)
                    begin
                        n_reg <= job.n;
                        d_reg <= job.d;
                        s_reg <= job.s;
                        k_reg <= '0;
                        if (job.cls == CLS_TEST)
                            state_reg <= B_BASE;
                        else
                            flag_reg <= (job.cls == CLS_PRIME);
                    end
                end
                B_BASE:
                begin
                    if (k_reg == 3'(NumBases))
                    begin
                        flag_reg  <= 1'b1;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        // base mod n: 1 times the base, scanned over the base bits
                        mm_a      <= word_t'(1);
                        mm_b      <= base_of(k_reg);
                        mm_start  <= 1'b1;
                        state_reg <= B_RED;
                    end
                end
                B_RED:
                begin
                    if (mm_done)
                    begin
                        // a base that is a multiple of n is skipped
                        if (mm_p == '0)
                        begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= B_BASE;
                        end
                        else
                        begin
                            sq_reg    <= mm_p;
                            x_reg     <= word_t'(1);
                            e_reg     <= d_reg;
                            state_reg <= B_POW;
                        end
                    end
                end
                B_POW:
                begin
                    if (e_reg == '0)
                        state_reg <= B_CHECK;
                    else if (e_reg[0])
                    begin
                        mm_a      <= sq_reg;
                        mm_b      <= x_reg;
                        mm_start  <= 1'b1;
                        state_reg <= B_PMUL;
                    end
                    else
                    begin
                        mm_a      <= sq_reg;
                        mm_b      <= sq_reg;
                        mm_start  <= 1'b1;
                        state_reg <= B_PSQ;
                    end
                end
                B_PMUL:
                begin
                    if (mm_done)
                    begin
                        x_reg     <= mm_p;
                        mm_a      <= sq_reg;
                        mm_b      <= sq_reg;
                        mm_start  <= 1'b1;
                        state_reg <= B_PSQ;
                    end
                end
                B_PSQ:
                begin
                    if (mm_done)
                    begin
                        sq_reg    <= mm_p;
                        e_reg     <= e_reg >> 1;
                        state_reg <= B_POW;
                    end
                end
                B_CHECK:
                begin
                    r_reg <= '0;
                    if (x_reg == word_t'(1) || x_reg == nm1)
                    begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= B_BASE;
                    end
                    else
                        state_reg <= B_SQR;
                end
                B_SQR:
                begin
                    if (r_reg == s_reg)
                    begin
                        flag_reg  <= 1'b0;
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        mm_a      <= x_reg;
                        mm_b      <= x_reg;
                        mm_start  <= 1'b1;
                        state_reg <= B_SQRW;
                    end
                end
                B_SQRW:
                begin
                    if (mm_done)
                    begin
                        x_reg <= mm_p;
                        r_reg <= r_reg + 6'd1;
                        if (mm_p == nm1)
                        begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= B_BASE;
                        end
                        else
                            state_reg <= B_SQR;
                    end
                end
                B_OUT:
                begin
                    if (!out_valid || !out_stall)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/miller_rabin_prime_test_64.sv =====
// path: trivial candidates (below two or even) go from the front end through the queue
// to the back end output register without the multiplier; odd ones take up to 7 bases x up
// to 128 modular products on the shared bit-serial multiplier
// throughput: one candidate in flight in the back end; the shared bit-serial
// modular multiplier (one bit per cycle) sets the rate
// reset: asynchronous active-low rst_n clears all control, any pending transfer is dropped
// depends on mrpt_pkg, mrpt_front, mrpt_queue, mrpt_back
module miller_rabin_prime_test_64
    import mrpt_pkg::*;
#(
    parameter int unsigned QDepth = QueueDepth
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  word_t candidate,
    output logic  out_valid,
    input  logic  out_stall,
    output logic  prime_flag
);

    // front to queue
    logic f_valid, f_stall;
    job_t f_job;
    // queue to back end
    logic b_valid, b_stall;
    job_t b_job;

    // front end: classify and strip powers of two from n-1
    mrpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .candidate (candidate),
        .job_valid (f_valid),
        .job_stall (f_stall),
        .job       (f_job)
    );

    // short queue lets the front take the next transfer while the back end works
    mrpt_queue #(.Depth(QDepth)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_data  (f_job),
        .rd_valid (b_valid),
        .rd_stall (b_stall),
        .rd_data  (b_job)
    );

    // back end: witness loop with one shared modular multiplier
    mrpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_stall (b_stall),
        .job       (b_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .flag      (prime_flag)
    );

endmodule
